// ===== rtl/gpc_pkg.sv =====
package gpc_pkg;

   // Default sizes of the pin mode store and of the line bank
   localparam int LOGICAL_PINS_DEF = 64;
   localparam int HW_LINES_DEF     = 54;

   // Fixed widths of the item fields
   localparam int PIN_W     = 6;
   localparam int LINE_W    = 6;
   localparam int FUNC_W    = 3;
   localparam int PAD_W     = 54;
   localparam int REQ_BITS  = 2 + PIN_W + 2 + 1 + PAD_W;
   localparam int RSP_BITS  = 2 + LINE_W + 1 + FUNC_W + PAD_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 2;

   localparam logic [FUNC_W-1:0] FUNC_INPUT  = 3'b000;
   localparam logic [FUNC_W-1:0] FUNC_OUTPUT = 3'b001;
   localparam logic [1:0]        MODE_UNSET  = 2'd3;
   localparam logic [1:0]        REV_ONE     = 2'd1;

   typedef enum logic [1:0] {
      OP_SET_MODE = 2'd0,
      OP_WRITE    = 2'd1,
      OP_READ     = 2'd2,
      OP_NOP      = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      PM_INPUT  = 2'd0,
      PM_OUTPUT = 2'd1,
      PM_OTHER  = 2'd2,
      PM_UNSET  = 2'd3
   } pin_mode_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_MISMATCH = 2'd1,
      STAT_UNSUP    = 2'd2,
      STAT_UNMAPPED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      NUM_WIRING = 2'd0,
      NUM_DIRECT = 2'd1,
      NUM_SYS    = 2'd2,
      NUM_HEADER = 2'd3
   } numbering_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUMBERING = 2'd0,
      CSR_REVISION  = 2'd1
   } csr_index_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic              ok;
      logic [LINE_W-1:0] line;
   } map_entry_type;

   // Result item, status in the lowest bits
   typedef struct packed {
      logic [PAD_W-1:0]  latch_bits;
      logic [FUNC_W-1:0] line_function;
      logic              read_level;
      logic [LINE_W-1:0] hw_line;
      status_type        status;
   } rsp_fields_type;

   function automatic map_entry_type mk(input logic [LINE_W-1:0] line);
      map_entry_type e;
      e.ok   = 1'b1;
      e.line = line;
      return e;
   endfunction

   function automatic map_entry_type wire_r1(input logic [PIN_W-1:0] pin);
      map_entry_type e;
      e = '0;
      case (pin)
         6'd0:  e = mk(6'd17);
         6'd1:  e = mk(6'd18);
         6'd2:  e = mk(6'd21);
         6'd3:  e = mk(6'd22);
         6'd4:  e = mk(6'd23);
         6'd5:  e = mk(6'd24);
         6'd6:  e = mk(6'd25);
         6'd7:  e = mk(6'd4);
         6'd8:  e = mk(6'd0);
         6'd9:  e = mk(6'd1);
         6'd10: e = mk(6'd8);
         6'd11: e = mk(6'd7);
         6'd12: e = mk(6'd10);
         6'd13: e = mk(6'd9);
         6'd14: e = mk(6'd11);
         6'd15: e = mk(6'd14);
         6'd16: e = mk(6'd15);
         default: e = '0;
      endcase
      return e;
   endfunction

   function automatic map_entry_type wire_r2(input logic [PIN_W-1:0] pin);
      map_entry_type e;
      e = '0;
      case (pin)
         6'd0:  e = mk(6'd17);
         6'd1:  e = mk(6'd18);
         6'd2:  e = mk(6'd27);
         6'd3:  e = mk(6'd22);
         6'd4:  e = mk(6'd23);
         6'd5:  e = mk(6'd24);
         6'd6:  e = mk(6'd25);
         6'd7:  e = mk(6'd4);
         6'd8:  e = mk(6'd2);
         6'd9:  e = mk(6'd3);
         6'd10: e = mk(6'd8);
         6'd11: e = mk(6'd7);
         6'd12: e = mk(6'd10);
         6'd13: e = mk(6'd9);
         6'd14: e = mk(6'd11);
         6'd15: e = mk(6'd14);
         6'd16: e = mk(6'd15);
         6'd17: e = mk(6'd28);
         6'd18: e = mk(6'd29);
         6'd19: e = mk(6'd30);
         6'd20: e = mk(6'd31);
         6'd21: e = mk(6'd5);
         6'd22: e = mk(6'd6);
         6'd23: e = mk(6'd13);
         6'd24: e = mk(6'd19);
         6'd25: e = mk(6'd26);
         6'd26: e = mk(6'd12);
         6'd27: e = mk(6'd16);
         6'd28: e = mk(6'd20);
         6'd29: e = mk(6'd21);
         6'd30: e = mk(6'd0);
         6'd31: e = mk(6'd1);
         default: e = '0;
      endcase
      return e;
   endfunction

   // Header positions shared by both revisions except three
   function automatic map_entry_type head_common(input logic [PIN_W-1:0] pin);
      map_entry_type e;
      e = '0;
      case (pin)
         6'd7:  e = mk(6'd4);
         6'd8:  e = mk(6'd14);
         6'd10: e = mk(6'd15);
         6'd11: e = mk(6'd17);
         6'd12: e = mk(6'd18);
         6'd15: e = mk(6'd22);
         6'd16: e = mk(6'd23);
         6'd18: e = mk(6'd24);
         6'd19: e = mk(6'd10);
         6'd21: e = mk(6'd9);
         6'd22: e = mk(6'd25);
         6'd23: e = mk(6'd11);
         6'd24: e = mk(6'd8);
         6'd26: e = mk(6'd7);
         default: e = '0;
      endcase
      return e;
   endfunction

   function automatic map_entry_type head_r1(input logic [PIN_W-1:0] pin);
      map_entry_type e;
      e = head_common(pin);
      case (pin)
         6'd3:  e = mk(6'd0);
         6'd5:  e = mk(6'd1);
         6'd13: e = mk(6'd21);
         default: e = head_common(pin);
      endcase
      return e;
   endfunction

   function automatic map_entry_type head_r2(input logic [PIN_W-1:0] pin);
      map_entry_type e;
      e = head_common(pin);
      case (pin)
         6'd3:  e = mk(6'd2);
         6'd5:  e = mk(6'd3);
         6'd13: e = mk(6'd27);
         6'd27: e = mk(6'd0);
         6'd28: e = mk(6'd1);
         6'd29: e = mk(6'd5);
         6'd31: e = mk(6'd6);
         6'd32: e = mk(6'd12);
         6'd33: e = mk(6'd13);
         6'd35: e = mk(6'd19);
         6'd36: e = mk(6'd16);
         6'd37: e = mk(6'd26);
         6'd38: e = mk(6'd20);
         6'd40: e = mk(6'd21);
         6'd51: e = mk(6'd28);
         6'd52: e = mk(6'd29);
         6'd53: e = mk(6'd30);
         6'd54: e = mk(6'd31);
         default: e = head_common(pin);
      endcase
      return e;
   endfunction

endpackage

// ===== rtl/gpio_pin_controller.sv =====
// Channel  | Direction | Handshake              | Contents
// req_     | in        | req_tvalid/req_tready  | one pin request item
// rsp_     | out       | rsp_tvalid/rsp_tready  | one result item per request
// csr_     | in        | csr_valid/csr_ready    | register index and write data
//
// The accept edge reads the pin mode and function stores into read registers;
// the modify state then modifies, writes back and loads the result register.
// The single read port of each store sets this split. Reset clears the valid
// bits of both stores, the latch, the configuration, the state and rsp_tvalid.
// A result waiting on rsp_ holds the block in its modify state; the next
// request is taken only once that item has moved into the result register.
module gpio_pin_controller
   import gpc_pkg::*;
#(
   parameter int LOGICAL_PINS = LOGICAL_PINS_DEF,
   parameter int HW_LINES     = HW_LINES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // opcode[1:0], pin[7:2], pin_mode[9:8], drive_value[10], pad_levels[64:11]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // status[1:0], hw_line[7:2], read_level[8], line_function[11:9],
   // latch_bits[65:12]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DAT_W-1:0]   csr_data
);

   localparam int PIN_IDX_W  = $clog2(LOGICAL_PINS);
   localparam int LINE_IDX_W = $clog2(HW_LINES);

   // Request fields
   opcode_type        req_op;
   logic [PIN_W-1:0]  req_pin;
   logic [1:0]        req_mode;
   logic              req_drive;
   logic [PAD_W-1:0]  req_pads;

   assign req_op    = opcode_type'(req_tdata[1:0]);
   assign req_pin   = req_tdata[7:2];
   assign req_mode  = req_tdata[9:8];
   assign req_drive = req_tdata[10];
   assign req_pads  = req_tdata[64:11];

   // Configuration
   numbering_type numbering_ff;
   logic [1:0]    revision_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         numbering_ff <= NUM_WIRING;
         revision_ff  <= 2'd2;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_NUMBERING: numbering_ff <= numbering_type'(csr_data);
            CSR_REVISION:  revision_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Sequencer
   state_type state_ff, state_in;
   logic      accept;
   logic      exec_load;
   logic      rsp_tvalid_ff;

   assign accept = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_EXEC;
         ST_EXEC: if (exec_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      exec_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_EXEC: exec_load  = !rsp_tvalid_ff || rsp_tready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // Map the logical pin to a line during the accept cycle
   logic          pin_ok;
   map_entry_type tab_entry;
   status_type    map_st;
   logic [LINE_W-1:0] map_line;

   assign pin_ok = {1'b0, req_pin} < 7'(LOGICAL_PINS);

   always_comb begin
      if (numbering_ff == NUM_WIRING) begin
         tab_entry = (revision_ff == REV_ONE) ? wire_r1(req_pin) : wire_r2(req_pin);
      end else begin
         tab_entry = (revision_ff == REV_ONE) ? head_r1(req_pin) : head_r2(req_pin);
      end
   end

   always_comb begin
      map_st   = STAT_OK;
      map_line = '0;
      case (numbering_ff)
         NUM_SYS: map_st = STAT_UNSUP;
         NUM_DIRECT: begin
            if ({1'b0, req_pin} < 7'(HW_LINES)) map_line = req_pin;
            else                                map_st   = STAT_UNMAPPED;
         end
         default: begin
            if (tab_entry.ok && ({1'b0, tab_entry.line} < 7'(HW_LINES))) begin
               map_line = tab_entry.line;
            end else begin
               map_st = STAT_UNMAPPED;
            end
         end
      endcase
   end

   // Hold the item for its modify state
   opcode_type        op_ff;
   logic              pin_ok_ff;
   logic [PIN_W-1:0]  pin_ff;
   logic [1:0]        mode_ff;
   logic              drive_ff;
   logic [PAD_W-1:0]  pads_ff;
   status_type        map_st_ff;
   logic [LINE_W-1:0] line_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_op;
         pin_ok_ff <= pin_ok;
         pin_ff    <= req_pin;
         mode_ff   <= req_mode;
         drive_ff  <= req_drive;
         pads_ff   <= req_pads;
         map_st_ff <= map_st;
         line_ff   <= map_line;
      end
   end

   // Pin mode store: one entry per logical pin, unset until written
   logic [1:0]            mode_mem_ff [LOGICAL_PINS];
   logic [LOGICAL_PINS-1:0] mode_vld_ff;
   logic [1:0]            mode_rd_ff;
   logic                  mode_rd_vld_ff;
   logic                  mode_we;
   logic [PIN_IDX_W-1:0]  rd_pin_idx;
   logic [PIN_IDX_W-1:0]  wr_pin_idx;

   assign rd_pin_idx = req_pin[PIN_IDX_W-1:0];
   assign wr_pin_idx = pin_ff[PIN_IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (mode_we) mode_mem_ff[wr_pin_idx] <= mode_ff;
      if (accept && pin_ok) begin
         mode_rd_ff     <= mode_mem_ff[rd_pin_idx];
         mode_rd_vld_ff <= mode_vld_ff[rd_pin_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset)        mode_vld_ff <= '0;
      else if (mode_we) mode_vld_ff[wr_pin_idx] <= 1'b1;
   end

   // Function field store: one entry per line, input until written
   logic [FUNC_W-1:0]     func_mem_ff [HW_LINES];
   logic [HW_LINES-1:0]   func_vld_ff;
   logic [FUNC_W-1:0]     func_rd_ff;
   logic                  func_rd_vld_ff;
   logic                  func_we;
   logic [FUNC_W-1:0]     func_wdata;
   logic [LINE_IDX_W-1:0] rd_line_idx;
   logic [LINE_IDX_W-1:0] wr_line_idx;

   assign rd_line_idx = map_line[LINE_IDX_W-1:0];
   assign wr_line_idx = line_ff[LINE_IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (func_we) func_mem_ff[wr_line_idx] <= func_wdata;
      if (accept && map_st == STAT_OK) begin
         func_rd_ff     <= func_mem_ff[rd_line_idx];
         func_rd_vld_ff <= func_vld_ff[rd_line_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset)        func_vld_ff <= '0;
      else if (func_we) func_vld_ff[wr_line_idx] <= 1'b1;
   end

   // Output latch
   logic [HW_LINES-1:0] latch_ff, latch_in;

   always_ff @(posedge clock) begin
      if (reset)          latch_ff <= '0;
      else if (exec_load) latch_ff <= latch_in;
   end

   // Modify stage
   logic           mode_cur;
   logic [1:0]     mode_eff;
   logic [FUNC_W-1:0] func_eff;
   logic           mismatch;
   logic           active;
   logic           mapped;
   rsp_fields_type res;

   assign mode_eff = mode_rd_vld_ff ? mode_rd_ff : MODE_UNSET;
   assign func_eff = func_rd_vld_ff ? func_rd_ff : FUNC_INPUT;
   assign mode_cur = 1'b0;

   assign mismatch = (op_ff == OP_WRITE && mode_eff != PM_OUTPUT) ||
                     (op_ff == OP_READ  && mode_eff != PM_INPUT);
   assign active   = (op_ff != OP_NOP) && pin_ok_ff && !mismatch;
   assign mapped   = active && (map_st_ff == STAT_OK);

   assign mode_we  = exec_load && active && (op_ff == OP_SET_MODE);

   always_comb begin
      func_we    = 1'b0;
      func_wdata = func_eff;
      if (exec_load && mapped && op_ff == OP_SET_MODE) begin
         if (mode_ff == PM_INPUT) begin
            func_we    = 1'b1;
            func_wdata = FUNC_INPUT;
         end else if (mode_ff == PM_OUTPUT) begin
            func_we    = 1'b1;
            func_wdata = FUNC_OUTPUT;
         end
      end
   end

   always_comb begin
      latch_in = latch_ff;
      if (mapped && op_ff == OP_WRITE) latch_in[wr_line_idx] = drive_ff;
   end

   always_comb begin
      res = '0;
      if (op_ff == OP_NOP)  res.status = STAT_OK;
      else if (!pin_ok_ff)  res.status = STAT_UNMAPPED;
      else if (mismatch)    res.status = STAT_MISMATCH;
      else                  res.status = map_st_ff;
      if (mapped) begin
         res.hw_line = line_ff;
         if (op_ff == OP_READ && ({1'b0, line_ff} < 7'(PAD_W))) begin
            res.read_level = pads_ff[line_ff];
         end
         if (op_ff == OP_SET_MODE && (mode_ff == PM_INPUT || mode_ff == PM_OUTPUT)) begin
            res.line_function = func_wdata;
         end else begin
            res.line_function = func_eff;
         end
      end
      for (int i = 0; i < PAD_W && i < HW_LINES; i++) begin
         res.latch_bits[i] = latch_in[i] | mode_cur;
      end
   end

   // Result register
   rsp_fields_type rsp_res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (exec_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_load) rsp_res_ff <= res;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_res_ff);

   // Checks
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EXEC))
      else $error("accepted item did not enter its modify cycle");

   a_fail_keeps_latch: assert property (@(posedge clock) disable iff (reset)
      (exec_load && res.status != STAT_OK) |=> $stable(latch_ff))
      else $error("failed item changed the output latch");

   a_unmapped_zero: assert property (@(posedge clock) disable iff (reset)
      (exec_load && res.status == STAT_UNMAPPED) |->
      (res.hw_line == '0 && res.line_function == '0 && res.read_level == 1'b0))
      else $error("unmapped item carries line data");

   a_mode_write: assert property (@(posedge clock) disable iff (reset)
      mode_we |-> (op_ff == OP_SET_MODE && pin_ok_ff && state_ff == ST_EXEC))
      else $error("pin mode store written outside a set-mode item");

endmodule
